@@ hdl/fsc_pkg.sv @@
// Shared types, constants and a helper function of the frame spike classifier.
package fsc_pkg;

    localparam int FRAME_W     = 20;
    localparam int FILL_W      = 9;
    localparam int SUM_W       = 28;
    localparam int COUNT_W     = 32;
    localparam int FACTOR_W    = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [FILL_W-1:0]  MIN_FILL  = 9'd10;
    localparam logic [COUNT_W-1:0] MINUTE_US = 32'd60000000;

    localparam logic ACTION_ANALYSE = 1'b0;
    localparam logic ACTION_CLEAR   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MILD_FACTOR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODERATE_FACTOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEVERE_FACTOR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_AVERAGE     = 3'd5;

    typedef enum logic [1:0] {
        GRADE_NONE,
        GRADE_MILD,
        GRADE_MODERATE,
        GRADE_SEVERE
    } grade_t;

    typedef enum logic [1:0] {
        OP_ANALYSE,
        OP_CLEAR,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        logic               action;
        logic [FRAME_W-1:0] frame_time_us;
    } sample_t;

    typedef struct packed {
        grade_t             hitch_class;
        grade_t             last_hitch_class;
        logic [COUNT_W-1:0] mild_total;
        logic [COUNT_W-1:0] moderate_total;
        logic [COUNT_W-1:0] severe_total;
        logic [FRAME_W-1:0] worst_hitch_us;
        logic [COUNT_W-1:0] per_minute_rate;
        logic [COUNT_W-1:0] frames_seen;
        logic [SUM_W-1:0]   window_total_us;
        logic [FILL_W-1:0]  window_count;
    } result_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [FRAME_W-1:0] sample;
        logic [FILL_W-1:0]  fill;
        logic [SUM_W-1:0]   sum;
    } win_item_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
        return (value == '1) ? value : value + 1'b1;
    endfunction

endpackage

@@ hdl/fsc_window.sv @@
// Sample ring, write slot, fill count and running window sum (first two pipeline stages).
module fsc_window #(
    parameter int HISTORY_DEPTH = 256,
    parameter int SAMPLE_W      = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       enable,
    input  logic [fsc_pkg::FILL_W-1:0] window_length,
    input  logic                       sample_valid,
    input  fsc_pkg::sample_t           sample_data,
    output logic                       sample_stall,
    input  logic                       down_free,
    output fsc_pkg::win_item_t         item
);
    import fsc_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic [SAMPLE_W-1:0] ring [HISTORY_DEPTH];

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    logic                a_valid_reg, a_valid_next;
    op_t                 a_op_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic [FILL_W-1:0]   a_fill_reg;
    logic                a_evict_reg;
    logic [SAMPLE_W-1:0] old_reg;

    logic                b_valid_reg, b_valid_next;
    op_t                 b_op_reg;
    logic [SAMPLE_W-1:0] b_sample_reg;
    logic [FILL_W-1:0]   b_fill_reg;
    logic [SUM_W-1:0]    b_sum_reg;

    logic [FILL_W-1:0]   win;
    logic [SLOT_W-1:0]   slot_eff;
    logic [SLOT_W-1:0]   slot_inc;
    logic                evict;
    logic [FILL_W-1:0]   fill_after;
    op_t                 in_op;
    logic [SAMPLE_W-1:0] in_sample;
    logic                accept;
    logic                a_move;
    logic                ring_we;

    always_comb
    begin
        if (window_length == '0)
        begin
            win = FILL_W'(1);
        end
        else if (32'(window_length) > HISTORY_DEPTH)
        begin
            win = FILL_W'(HISTORY_DEPTH);
        end
        else
        begin
            win = window_length;
        end
    end

    always_comb
    begin
        slot_eff   = (32'(slot_reg) >= 32'(win)) ? '0 : slot_reg;
        slot_inc   = (32'(slot_eff) + 32'd1 >= 32'(win)) ? '0 : slot_eff + 1'b1;
        evict      = (fill_reg >= win);
        fill_after = evict ? fill_reg : fill_reg + 1'b1;
        in_sample  = sample_data.frame_time_us[SAMPLE_W-1:0];
        if (sample_data.action == ACTION_CLEAR)
        begin
            in_op = OP_CLEAR;
        end
        else if (enable)
        begin
            in_op = OP_ANALYSE;
        end
        else
        begin
            in_op = OP_IGNORE;
        end
    end

    assign a_move       = a_valid_reg && (!b_valid_reg || down_free);
    assign sample_stall = a_valid_reg && !a_move;
    assign accept       = sample_valid && !sample_stall;
    assign ring_we      = accept && (in_op == OP_ANALYSE);

    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            case (in_op)
                OP_ANALYSE:
                begin
                    slot_next = slot_inc;
                    fill_next = fill_after;
                end
                OP_CLEAR:
                begin
                    slot_next = '0;
                    fill_next = '0;
                end
                default:
                begin
                    slot_next = slot_reg;
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (a_move)
        begin
            case (a_op_reg)
                OP_ANALYSE:
                begin
                    sum_next = sum_reg - (a_evict_reg ? SUM_W'(old_reg) : '0)
                               + SUM_W'(a_sample_reg);
                end
                OP_CLEAR:
                begin
                    sum_next = '0;
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    assign a_valid_next = accept || (a_valid_reg && !a_move);
    assign b_valid_next = a_move || (b_valid_reg && !down_free);

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[slot_eff] <= in_sample;
        end
        if (accept)
        begin
            old_reg <= ring[slot_eff];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg     <= in_op;
            a_sample_reg <= in_sample;
            a_fill_reg   <= fill_next;
            a_evict_reg  <= evict;
        end
        if (a_move)
        begin
            b_op_reg     <= a_op_reg;
            b_sample_reg <= a_sample_reg;
            b_fill_reg   <= a_fill_reg;
            b_sum_reg    <= sum_next;
        end
    end

    assign item.valid  = b_valid_reg;
    assign item.op     = b_op_reg;
    assign item.sample = FRAME_W'(b_sample_reg);
    assign item.fill   = b_fill_reg;
    assign item.sum    = b_sum_reg;

endmodule

@@ hdl/frame_spike_classifier.sv @@
// Top level of the frame spike classifier: configuration, threshold products and statistics.
//
//  channel       | signals                                     | transaction
//  --------------+---------------------------------------------+---------------------------
//  sample        | sample_valid, sample_stall, sample_data     | valid high and stall low
//  result        | result_valid, result_stall, result_data     | valid high and stall low
//  configuration | cfg_write_enable, cfg_index, cfg_write_data | write enable high
//
// One transaction is taken per cycle while sample_stall is low; its result is registered
// after the ring read, the window sum update, the threshold products and the grading stage.
// Reset clears the pipeline, the ring pointers and all statistics; ring contents are left
// as they are, and an entry read back is subtracted only when the window is full.
// While result_stall holds the output register, earlier stages still fill their empty
// slots, and sample_stall rises only once all four stages are occupied.
module frame_spike_classifier #(
    parameter int HISTORY_DEPTH = 256,
    parameter int SAMPLE_BITS   = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  fsc_pkg::sample_t                sample_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output fsc_pkg::result_t                result_data,
    input  logic                            cfg_write_enable,
    input  logic [fsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_write_data
);
    import fsc_pkg::*;

    localparam int SAMPLE_W = (SAMPLE_BITS < FRAME_W) ? SAMPLE_BITS : FRAME_W;
    localparam int LHS_W    = FRAME_W + FILL_W;
    localparam int RHS_W    = SUM_W + FACTOR_W;

    logic                enable_reg;
    logic [FILL_W-1:0]   window_length_reg;
    logic [FACTOR_W-1:0] mild_factor_reg;
    logic [FACTOR_W-1:0] moderate_factor_reg;
    logic [FACTOR_W-1:0] severe_factor_reg;
    logic [FRAME_W-1:0]  min_average_reg;

    win_item_t           item;
    logic                c_free;

    logic                c_valid_reg, c_valid_next;
    op_t                 c_op_reg;
    logic [FRAME_W-1:0]  c_sample_reg;
    logic [FILL_W-1:0]   c_fill_reg;
    logic [SUM_W-1:0]    c_sum_reg;
    logic [LHS_W+7:0]    c_lhs_reg;
    logic [RHS_W-1:0]    c_severe_reg;
    logic [RHS_W-1:0]    c_moderate_reg;
    logic [RHS_W-1:0]    c_mild_reg;
    logic [LHS_W-1:0]    c_floor_reg;
    logic                c_load;
    logic                c_move;
    logic                d_free;

    logic [COUNT_W-1:0]  mild_total_reg, mild_total_next;
    logic [COUNT_W-1:0]  moderate_total_reg, moderate_total_next;
    logic [COUNT_W-1:0]  severe_total_reg, severe_total_next;
    logic [FRAME_W-1:0]  worst_reg, worst_next;
    grade_t              last_grade_reg, last_grade_next;
    logic [COUNT_W-1:0]  frames_reg, frames_next;
    logic [COUNT_W-1:0]  minute_hits_reg, minute_hits_next;
    logic [COUNT_W-1:0]  elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]  rate_reg, rate_next;

    logic                result_valid_reg, result_valid_next;
    result_t             result_reg;

    logic [LHS_W+7:0]    lhs;
    logic                below_min;
    logic                qualify;
    grade_t              grade;
    grade_t              hitch;
    logic [COUNT_W:0]    elapsed_sum;
    logic [COUNT_W-1:0]  elapsed_add;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg          <= 1'b1;
            window_length_reg   <= FILL_W'(60);
            mild_factor_reg     <= FACTOR_W'(384);
            moderate_factor_reg <= FACTOR_W'(512);
            severe_factor_reg   <= FACTOR_W'(768);
            min_average_reg     <= '0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_ENABLE:          enable_reg          <= cfg_write_data[0];
                REG_WINDOW_LENGTH:   window_length_reg   <= cfg_write_data[FILL_W-1:0];
                REG_MILD_FACTOR:     mild_factor_reg     <= cfg_write_data[FACTOR_W-1:0];
                REG_MODERATE_FACTOR: moderate_factor_reg <= cfg_write_data[FACTOR_W-1:0];
                REG_SEVERE_FACTOR:   severe_factor_reg   <= cfg_write_data[FACTOR_W-1:0];
                REG_MIN_AVERAGE:     min_average_reg     <= cfg_write_data[FRAME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    fsc_window #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_W      (SAMPLE_W)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (enable_reg),
        .window_length (window_length_reg),
        .sample_valid  (sample_valid),
        .sample_data   (sample_data),
        .sample_stall  (sample_stall),
        .down_free     (c_free),
        .item          (item)
    );

    assign d_free            = !result_valid_reg || !result_stall;
    assign c_move            = c_valid_reg && d_free;
    assign c_free            = !c_valid_reg || c_move;
    assign c_load            = item.valid && c_free;
    assign c_valid_next      = c_load || (c_valid_reg && !c_move);
    assign result_valid_next = c_move || (result_valid_reg && result_stall);

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_op_reg       <= item.op;
            c_sample_reg   <= item.sample;
            c_fill_reg     <= item.fill;
            c_sum_reg      <= item.sum;
            c_lhs_reg      <= {LHS_W'(item.sample * item.fill), 8'd0};
            c_severe_reg   <= RHS_W'(item.sum * severe_factor_reg);
            c_moderate_reg <= RHS_W'(item.sum * moderate_factor_reg);
            c_mild_reg     <= RHS_W'(item.sum * mild_factor_reg);
            c_floor_reg    <= LHS_W'(min_average_reg * item.fill);
        end
    end

    always_comb
    begin
        lhs       = c_lhs_reg;
        below_min = ({1'b0, c_sum_reg} < c_floor_reg);
        qualify   = (c_op_reg == OP_ANALYSE) && (c_fill_reg >= MIN_FILL) && !below_min;
        if (RHS_W'(lhs) >= c_severe_reg)
        begin
            grade = GRADE_SEVERE;
        end
        else if (RHS_W'(lhs) >= c_moderate_reg)
        begin
            grade = GRADE_MODERATE;
        end
        else if (RHS_W'(lhs) >= c_mild_reg)
        begin
            grade = GRADE_MILD;
        end
        else
        begin
            grade = GRADE_NONE;
        end
        hitch       = qualify ? grade : GRADE_NONE;
        elapsed_sum = {1'b0, elapsed_reg} + (COUNT_W + 1)'(c_sample_reg);
        elapsed_add = elapsed_sum[COUNT_W] ? '1 : elapsed_sum[COUNT_W-1:0];
    end

    always_comb
    begin
        mild_total_next     = mild_total_reg;
        moderate_total_next = moderate_total_reg;
        severe_total_next   = severe_total_reg;
        worst_next          = worst_reg;
        last_grade_next     = last_grade_reg;
        frames_next         = frames_reg;
        minute_hits_next    = minute_hits_reg;
        elapsed_next        = elapsed_reg;
        rate_next           = rate_reg;
        if (c_move)
        begin
            case (c_op_reg)
                OP_CLEAR:
                begin
                    mild_total_next     = '0;
                    moderate_total_next = '0;
                    severe_total_next   = '0;
                    worst_next          = '0;
                    last_grade_next     = GRADE_NONE;
                    frames_next         = '0;
                    minute_hits_next    = '0;
                    elapsed_next        = '0;
                    rate_next           = '0;
                end
                OP_ANALYSE:
                begin
                    frames_next  = sat_inc(frames_reg);
                    elapsed_next = elapsed_add;
                    if (hitch != GRADE_NONE)
                    begin
                        last_grade_next  = hitch;
                        minute_hits_next = sat_inc(minute_hits_reg);
                        if (c_sample_reg > worst_reg)
                        begin
                            worst_next = c_sample_reg;
                        end
                        case (hitch)
                            GRADE_MILD:     mild_total_next     = sat_inc(mild_total_reg);
                            GRADE_MODERATE: moderate_total_next = sat_inc(moderate_total_reg);
                            GRADE_SEVERE:   severe_total_next   = sat_inc(severe_total_reg);
                            default:
                            begin
                            end
                        endcase
                    end
                    if (qualify && (elapsed_add >= MINUTE_US))
                    begin
                        rate_next        = minute_hits_next;
                        minute_hits_next = '0;
                        elapsed_next     = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg        <= 1'b0;
            result_valid_reg   <= 1'b0;
            mild_total_reg     <= '0;
            moderate_total_reg <= '0;
            severe_total_reg   <= '0;
            worst_reg          <= '0;
            last_grade_reg     <= GRADE_NONE;
            frames_reg         <= '0;
            minute_hits_reg    <= '0;
            elapsed_reg        <= '0;
            rate_reg           <= '0;
        end
        else
        begin
            c_valid_reg        <= c_valid_next;
            result_valid_reg   <= result_valid_next;
            mild_total_reg     <= mild_total_next;
            moderate_total_reg <= moderate_total_next;
            severe_total_reg   <= severe_total_next;
            worst_reg          <= worst_next;
            last_grade_reg     <= last_grade_next;
            frames_reg         <= frames_next;
            minute_hits_reg    <= minute_hits_next;
            elapsed_reg        <= elapsed_next;
            rate_reg           <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_move)
        begin
            result_reg.hitch_class      <= hitch;
            result_reg.last_hitch_class <= last_grade_next;
            result_reg.mild_total       <= mild_total_next;
            result_reg.moderate_total   <= moderate_total_next;
            result_reg.severe_total     <= severe_total_next;
            result_reg.worst_hitch_us   <= worst_next;
            result_reg.per_minute_rate  <= rate_next;
            result_reg.frames_seen      <= frames_next;
            result_reg.window_total_us  <= c_sum_reg;
            result_reg.window_count     <= c_fill_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

@@ hdl/fsc_checker.sv @@
// Port-level assertions for the frame spike classifier and their binding to the top level.
module fsc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input fsc_pkg::result_t result_data
);
    import fsc_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("Stalled result transaction changed or was dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.hitch_class != GRADE_NONE)
        |-> result_data.last_hitch_class == result_data.hitch_class)
    else $error("Last hitch grade does not follow the current hitch.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.hitch_class != GRADE_NONE)
        |-> result_data.window_count >= MIN_FILL)
    else $error("Hitch graded before the window held enough samples.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.window_count == '0)
        |-> result_data.window_total_us == '0)
    else $error("Empty window reports a non-zero sum.");

endmodule

bind frame_spike_classifier fsc_checker u_fsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
